>>> hw/rtl/isl_pkg.sv
// isl_pkg: shared types, codes and widths for the indexed shift list
// no dependencies; used by every other file of the block

package isl_pkg;

    // default and limit sizes of the list
    localparam int CAPACITY_DEF   = 16;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int CAPACITY_MAX   = 64;
    localparam int CNT_W_MAX      = $clog2(CAPACITY_MAX + 1);

    // fixed field widths of the command and response channels
    localparam int CMD_W    = 3;
    localparam int POS_W    = 5;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // command codes; the two unused codes fall to the default arm
    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_BACK  = 3'd0,
        CMD_PUSH_FRONT = 3'd1,
        CMD_POP_BACK   = 3'd2,
        CMD_POP_FRONT  = 3'd3,
        CMD_INSERT     = 3'd4,
        CMD_ERASE      = 3'd5
    } t_cmd;

    // response status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_BAD_INDEX = 2'd3
    } t_status;

    // what the cell row does in this cycle
    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_OPEN  = 2'd1,
        OP_CLOSE = 2'd2
    } t_op_kind;

    // broadcast to every cell: operation, slot index and count before it
    typedef struct packed {
        t_op_kind               kind;
        logic [CNT_W_MAX-1:0]   at;
        logic [CNT_W_MAX-1:0]   cnt;
    } t_list_op;

    // controller verdict for one command
    typedef struct packed {
        t_status                status;
        logic [CNT_W_MAX-1:0]   count;
    } t_ctl_result;

endpackage

>>> hw/rtl/isl_if.sv
// isl_if: valid/ready channels for list commands and responses
// depends on isl_pkg for the field widths

interface isl_cmd_if;
    logic                              valid;
    logic                              ready;
    logic [isl_pkg::CMD_W-1:0]         cmd;
    logic [isl_pkg::POS_W-1:0]         position;
    logic signed [isl_pkg::VAL_W-1:0]  value_in;

    modport source (output valid, cmd, position, value_in, input ready);
    modport sink   (input valid, cmd, position, value_in, output ready);
endinterface

interface isl_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [isl_pkg::STATUS_W-1:0]      status;
    logic signed [isl_pkg::VAL_W-1:0]  value_out;
    logic [isl_pkg::COUNT_W-1:0]       count;

    modport source (output valid, status, value_out, count, input ready);
    modport sink   (input valid, status, value_out, count, output ready);
endinterface

>>> hw/rtl/isl_cell.sv
// isl_cell: one slot of the list, shifts to or from its neighbors
// depends on isl_pkg for the broadcast operation type

module isl_cell #(
    parameter int IDX        = 0,
    parameter int DATA_WIDTH = isl_pkg::DATA_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  isl_pkg::t_list_op       i_op,
    input  logic [DATA_WIDTH-1:0]   i_value,
    input  logic [DATA_WIDTH-1:0]   i_left,
    input  logic [DATA_WIDTH-1:0]   i_right,
    output logic [DATA_WIDTH-1:0]   o_data
);

    localparam logic [isl_pkg::CNT_W_MAX-1:0] MY_IDX  = isl_pkg::CNT_W_MAX'(IDX);
    localparam logic [isl_pkg::CNT_W_MAX-1:0] NEXT_IDX = isl_pkg::CNT_W_MAX'(IDX + 1);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;

    // open: load at the slot, later held slots take the left neighbor
    // close: slots from the hole on take the right neighbor
    always_comb begin
        n_data = r_data;
        case (i_op.kind)
            isl_pkg::OP_OPEN: begin
                if (MY_IDX == i_op.at) begin
                    n_data = i_value;
                end else if (MY_IDX > i_op.at && MY_IDX <= i_op.cnt) begin
                    n_data = i_left;
                end
            end
            isl_pkg::OP_CLOSE: begin
                if (MY_IDX >= i_op.at && NEXT_IDX < i_op.cnt) begin
                    n_data = i_right;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    // slot storage, no reset
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

>>> hw/rtl/isl_ctrl.sv
// isl_ctrl: command decode, status checks and element count register
// depends on isl_pkg for command, status and operation types

module isl_ctrl #(
    parameter int CAPACITY = isl_pkg::CAPACITY_DEF,
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_fire,
    input  logic [isl_pkg::CMD_W-1:0]    i_cmd,
    input  logic [isl_pkg::POS_W-1:0]    i_position,
    output isl_pkg::t_list_op            o_op,
    output isl_pkg::t_ctl_result         o_result
);

    localparam int CMP_W = (CNT_W > isl_pkg::POS_W) ? CNT_W : isl_pkg::POS_W;

    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       n_count;
    logic [CMP_W-1:0]       w_pos;
    logic [CMP_W-1:0]       w_cnt;
    logic                   w_full;
    logic                   w_empty;
    isl_pkg::t_status       w_status;
    isl_pkg::t_op_kind      w_kind;
    logic [CNT_W-1:0]       w_at;

    assign w_pos   = CMP_W'(i_position);
    assign w_cnt   = CMP_W'(r_count);
    assign w_full  = (r_count == CNT_W'(CAPACITY));
    assign w_empty = (r_count == '0);

    // decode the command against the current count
    always_comb begin
        w_status = isl_pkg::ST_OK;
        w_kind   = isl_pkg::OP_NONE;
        w_at     = '0;
        n_count  = r_count;
        case (isl_pkg::t_cmd'(i_cmd))
            isl_pkg::CMD_PUSH_BACK: begin
                if (w_full) begin
                    w_status = isl_pkg::ST_FULL;
                end else begin
                    w_kind  = isl_pkg::OP_OPEN;
                    w_at    = r_count;
                    n_count = r_count + CNT_W'(1);
                end
            end
            isl_pkg::CMD_PUSH_FRONT: begin
                if (w_full) begin
                    w_status = isl_pkg::ST_FULL;
                end else begin
                    w_kind  = isl_pkg::OP_OPEN;
                    n_count = r_count + CNT_W'(1);
                end
            end
            isl_pkg::CMD_POP_BACK: begin
                if (w_empty) begin
                    w_status = isl_pkg::ST_EMPTY;
                end else begin
                    w_kind  = isl_pkg::OP_CLOSE;
                    w_at    = r_count - CNT_W'(1);
                    n_count = r_count - CNT_W'(1);
                end
            end
            isl_pkg::CMD_POP_FRONT: begin
                if (w_empty) begin
                    w_status = isl_pkg::ST_EMPTY;
                end else begin
                    w_kind  = isl_pkg::OP_CLOSE;
                    n_count = r_count - CNT_W'(1);
                end
            end
            isl_pkg::CMD_INSERT: begin
                if (w_pos > w_cnt) begin
                    w_status = isl_pkg::ST_BAD_INDEX;
                end else if (w_full) begin
                    w_status = isl_pkg::ST_FULL;
                end else begin
                    w_kind  = isl_pkg::OP_OPEN;
                    w_at    = CNT_W'(w_pos);
                    n_count = r_count + CNT_W'(1);
                end
            end
            isl_pkg::CMD_ERASE: begin
                if (w_empty) begin
                    w_status = isl_pkg::ST_EMPTY;
                end else if (w_pos >= w_cnt) begin
                    w_status = isl_pkg::ST_BAD_INDEX;
                end else begin
                    w_kind  = isl_pkg::OP_CLOSE;
                    w_at    = CNT_W'(w_pos);
                    n_count = r_count - CNT_W'(1);
                end
            end
            default: begin
                w_status = isl_pkg::ST_OK;
            end
        endcase
    end

    // broadcast to the cells only on a transfer
    always_comb begin
        o_op.kind       = i_fire ? w_kind : isl_pkg::OP_NONE;
        o_op.at         = isl_pkg::CNT_W_MAX'(w_at);
        o_op.cnt        = isl_pkg::CNT_W_MAX'(r_count);
        o_result.status = w_status;
        o_result.count  = isl_pkg::CNT_W_MAX'(n_count);
    end

    // element count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_fire) begin
            r_count <= n_count;
        end
    end

endmodule

>>> hw/rtl/indexed_shift_list.sv
// indexed_shift_list: fixed-capacity ordered list built from a row of shift cells
// depends on isl_pkg, isl_if, isl_cell and isl_ctrl
//
//  channel  | dir | fields                         | transfer when
//  ---------+-----+--------------------------------+--------------------------
//  i_cmd    | in  | cmd, position, value_in        | valid && ready
//  o_rsp    | out | status, value_out, count       | valid && ready
//
// one command per cycle while no stalled response holds the register: the cells shift in the cycle of the transfer
// the response sits in an output register in the cycle after the transfer
// i_cmd.ready is high while that register is empty or being taken
// reset clears the count and the response valid; cell contents stay undefined
// a stalled response holds the register and stops new commands

module indexed_shift_list #(
    parameter int CAPACITY   = isl_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = isl_pkg::DATA_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    isl_cmd_if.sink   i_cmd,
    isl_rsp_if.source o_rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic                             w_fire;
    isl_pkg::t_list_op                w_op;
    isl_pkg::t_ctl_result             w_result;
    logic [DATA_WIDTH-1:0]            w_value;
    logic [DATA_WIDTH-1:0]            w_cell [CAPACITY];
    logic signed [DATA_WIDTH-1:0]     w_removed;

    logic                             r_out_valid;
    logic [isl_pkg::STATUS_W-1:0]     r_status;
    logic signed [isl_pkg::VAL_W-1:0] r_value;
    logic [isl_pkg::COUNT_W-1:0]      r_count;

    assign i_cmd.ready = !r_out_valid || o_rsp.ready;
    assign w_fire      = i_cmd.valid && i_cmd.ready;
    assign w_value     = DATA_WIDTH'(i_cmd.value_in);

    // command decode and count
    isl_ctrl #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (w_fire),
        .i_cmd      (i_cmd.cmd),
        .i_position (i_cmd.position),
        .o_op       (w_op),
        .o_result   (w_result)
    );

    // row of cells, ends tied off
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] w_left;
        logic [DATA_WIDTH-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_cell[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_cell[g+1];
        end

        isl_cell #(
            .IDX        (g),
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_op    (w_op),
            .i_value (w_value),
            .i_left  (w_left),
            .i_right (w_right),
            .o_data  (w_cell[g])
        );
    end

    // pick the removed element out of the slot being closed
    always_comb begin
        w_removed = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (w_op.kind == isl_pkg::OP_CLOSE &&
                w_op.at == isl_pkg::CNT_W_MAX'(i)) begin
                w_removed = w_removed | w_cell[i];
            end
        end
    end

    // response register, valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // response register, payload
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_status <= w_result.status;
            r_value  <= isl_pkg::VAL_W'(w_removed);
            r_count  <= isl_pkg::COUNT_W'(w_result.count);
        end
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.status    = r_status;
    assign o_rsp.value_out = r_value;
    assign o_rsp.count     = r_count;

endmodule

>>> hw/rtl/isl_checker.sv
// isl_checker: port-level checks on the indexed shift list responses
// depends on isl_pkg for status codes; bound to indexed_shift_list below

module isl_checker #(
    parameter int CAPACITY = isl_pkg::CAPACITY_DEF
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_cmd_valid,
    input logic                              i_cmd_ready,
    input logic                              i_rsp_valid,
    input logic                              i_rsp_ready,
    input logic [isl_pkg::STATUS_W-1:0]      i_status,
    input logic signed [isl_pkg::VAL_W-1:0]  i_value_out,
    input logic [isl_pkg::COUNT_W-1:0]       i_count
);

    // a command transfer always yields a response on the next cycle
    a_rsp_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_valid && i_cmd_ready |=> i_rsp_valid)
        else $error("no response after command transfer");

    // a stalled response blocks new commands
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |-> !i_cmd_ready)
        else $error("command taken while response stalled");

    // a full report comes only with a full list
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_status == isl_pkg::ST_FULL |->
            i_count == isl_pkg::COUNT_W'(CAPACITY) && i_value_out == '0)
        else $error("full status with wrong count or value");

    // an empty report comes only with an empty list
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_status == isl_pkg::ST_EMPTY |->
            i_count == '0 && i_value_out == '0)
        else $error("empty status with wrong count or value");

    // a held response keeps its payload
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=>
            i_rsp_valid && $stable(i_status) && $stable(i_value_out) && $stable(i_count))
        else $error("stalled response changed");

endmodule

bind indexed_shift_list isl_checker #(
    .CAPACITY (CAPACITY)
) u_isl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cmd_valid (i_cmd.valid),
    .i_cmd_ready (i_cmd.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_status    (o_rsp.status),
    .i_value_out (o_rsp.value_out),
    .i_count     (o_rsp.count)
);
